@@ rtl/bdsw_pkg.sv @@
package bdsw_pkg;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 48;
    localparam int SIZE_W = 16;
    localparam int OP_W   = 8;

    // opcode field positions
    localparam int OP_REL_SHIFT = 3;
    localparam int OP_CLS_SHIFT = 1;

    // seek width class limits
    localparam logic [OFF_W-1:0] SEEK_LIM_8  = OFF_W'(64'h100);
    localparam logic [OFF_W-1:0] SEEK_LIM_16 = OFF_W'(64'h10000);
    localparam logic [OFF_W-1:0] SEEK_LIM_32 = OFF_W'(64'h100000000);
    localparam logic [SIZE_W-1:0] SIZE_WIDE  = SIZE_W'(32'h100);

    localparam logic [1:0] CLS_8  = 2'd0;
    localparam logic [1:0] CLS_16 = 2'd1;
    localparam logic [1:0] CLS_32 = 2'd2;
    localparam logic [1:0] CLS_48 = 2'd3;

    localparam logic KIND_HDR  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // APB register map
    localparam int  PADDR_W   = 4;
    localparam int  PDATA_W   = 64;
    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_OPBASE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [OP_W-1:0]   opcode;
        logic [OFF_W-1:0]  seek_offset;
        logic [SIZE_W-1:0] size_minus_one;
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_burst;
    } t_result;

    // sequencer to output queue
    typedef struct packed {
        logic    hdr_push;
        logic    rd_en;
        logic    rd_eob;
        t_result hdr;
    } t_issue;

endpackage

@@ rtl/bdsw_if.sv @@
interface bdsw_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdsw_pkg::BYTE_W-1:0]   old_byte;
    logic [bdsw_pkg::BYTE_W-1:0]   new_byte;
    logic                          old_present;
    logic                          last;

    modport source (output valid, old_byte, new_byte, old_present, last, input ready);
    modport sink   (input valid, old_byte, new_byte, old_present, last, output ready);
endinterface

interface bdsw_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [bdsw_pkg::OP_W-1:0]     opcode;
    logic [bdsw_pkg::OFF_W-1:0]    seek_offset;
    logic [bdsw_pkg::SIZE_W-1:0]   size_minus_one;
    logic [bdsw_pkg::BYTE_W-1:0]   data_byte;
    logic                          end_of_burst;

    modport source (output valid, kind, opcode, seek_offset, size_minus_one, data_byte,
                    end_of_burst, input ready);
    modport sink   (input valid, kind, opcode, seek_offset, size_minus_one, data_byte,
                    end_of_burst, output ready);
endinterface

@@ rtl/bdsw_store.sv @@
module bdsw_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [bdsw_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [bdsw_pkg::BYTE_W-1:0] o_rd_data
);

    logic [bdsw_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [bdsw_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/bdsw_oq.sv @@
module bdsw_oq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bdsw_pkg::t_issue            i_iss,
    input  logic [bdsw_pkg::BYTE_W-1:0] i_rd_data,
    output logic                        o_credit,
    bdsw_out_if.source                  o_rslt
);

    bdsw_pkg::t_result r_q [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              r_pend;
    logic              r_pend_eob;

    bdsw_pkg::t_result head;
    bdsw_pkg::t_result push_item;
    logic              push;
    logic              pop;
    logic [2:0]        occ;

    always_comb begin
        head = r_q[r_rp];
        pop  = (r_cnt != 2'd0) && o_rslt.ready;
        push = i_iss.hdr_push || r_pend;
        if (i_iss.hdr_push) begin
            push_item = i_iss.hdr;
        end else begin
            push_item                = '0;
            push_item.kind           = bdsw_pkg::KIND_DATA;
            push_item.data_byte      = i_rd_data;
            push_item.end_of_burst   = r_pend_eob;
        end
        // queued items plus the read in flight, less what leaves now
        occ      = 3'({1'b0, r_cnt}) + 3'(r_pend) - 3'(pop);
        o_credit = occ <= 3'd1;

        o_rslt.valid          = r_cnt != 2'd0;
        o_rslt.kind           = head.kind;
        o_rslt.opcode         = head.opcode;
        o_rslt.seek_offset    = head.seek_offset;
        o_rslt.size_minus_one = head.size_minus_one;
        o_rslt.data_byte      = head.data_byte;
        o_rslt.end_of_burst   = head.end_of_burst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_iss.rd_en;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_eob <= i_iss.rd_eob;
        if (push) begin
            r_q[r_wp] <= push_item;
        end
    end

endmodule

@@ rtl/bdsw_ctrl.sv @@
module bdsw_ctrl #(
    parameter int RUN_MAX = 32,
    parameter int LW      = 6,
    parameter int AW      = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bdsw_in_if.sink                     i_item,
    input  logic [bdsw_pkg::OFF_W-1:0]  i_region_offset,
    input  logic [bdsw_pkg::OP_W-1:0]   i_opcode_base,
    input  logic                        i_credit,
    output bdsw_pkg::t_issue            o_iss,
    output logic [AW-1:0]               o_rd_addr,
    output logic                        o_wr_en,
    output logic [AW-1:0]               o_wr_addr,
    output logic [bdsw_pkg::BYTE_W-1:0] o_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_APP  = 2'd3;

    localparam logic [LW-1:0] MAX_L = LW'(RUN_MAX);

    logic [1:0]                  r_state, n_state;
    logic [LW-1:0]               r_len, n_len;
    logic [bdsw_pkg::OFF_W-1:0]  r_run_start, n_run_start;
    logic [bdsw_pkg::OFF_W-1:0]  r_pos, n_pos;
    logic [bdsw_pkg::OFF_W-1:0]  r_prior, n_prior;
    logic                        r_abs, n_abs;
    logic                        r_tail, n_tail;
    logic                        r_second, n_second;

    logic [AW-1:0]               r_idx, n_idx;
    logic                        r_f2, n_f2;
    logic                        r_differs, n_differs;
    logic                        r_present, n_present;
    logic                        r_last, n_last;
    logic [bdsw_pkg::BYTE_W-1:0] r_new, n_new;

    logic                        accept;
    logic                        differs;
    logic                        f1;
    logic [LW-1:0]               len_after;
    logic [LW-1:0]               len_m1;
    logic                        last_rd;
    logic                        finish;
    logic [bdsw_pkg::OFF_W-1:0]  seek;
    logic [bdsw_pkg::SIZE_W-1:0] sz;
    logic [1:0]                  cls;
    bdsw_pkg::t_result           hdr;

    assign i_item.ready = r_state == S_IDLE;
    assign accept       = i_item.valid && i_item.ready;

    // header fields for the held run
    always_comb begin
        seek   = bdsw_pkg::OFF_W'(i_region_offset + r_run_start - r_prior);
        len_m1 = r_len - 1'b1;
        sz     = bdsw_pkg::SIZE_W'(len_m1);
        priority if (seek < bdsw_pkg::SEEK_LIM_8) begin
            cls = bdsw_pkg::CLS_8;
        end else if (seek < bdsw_pkg::SEEK_LIM_16) begin
            cls = bdsw_pkg::CLS_16;
        end else if (seek < bdsw_pkg::SEEK_LIM_32) begin
            cls = bdsw_pkg::CLS_32;
        end else begin
            cls = bdsw_pkg::CLS_48;
        end
        hdr                = '0;
        hdr.kind           = bdsw_pkg::KIND_HDR;
        hdr.opcode         = i_opcode_base
                           | (bdsw_pkg::OP_W'(!r_abs) << bdsw_pkg::OP_REL_SHIFT)
                           | (bdsw_pkg::OP_W'(cls) << bdsw_pkg::OP_CLS_SHIFT)
                           | bdsw_pkg::OP_W'(sz >= bdsw_pkg::SIZE_WIDE);
        hdr.seek_offset    = seek;
        hdr.size_minus_one = sz;
    end

    // decisions taken when the item arrives
    always_comb begin
        differs   = !i_item.old_present || (i_item.old_byte != i_item.new_byte);
        f1        = (r_len != '0) && (!differs || (r_tail == i_item.old_present));
        len_after = (f1 ? '0 : r_len) + 1'b1;
    end

    assign last_rd = LW'(r_idx) == len_m1;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_run_start = r_run_start;
        n_pos       = r_pos;
        n_prior     = r_prior;
        n_abs       = r_abs;
        n_tail      = r_tail;
        n_second    = r_second;
        n_idx       = r_idx;
        n_f2        = r_f2;
        n_differs   = r_differs;
        n_present   = r_present;
        n_last      = r_last;
        n_new       = r_new;
        finish      = 1'b0;

        o_iss.hdr      = hdr;
        o_iss.hdr_push = 1'b0;
        o_iss.rd_en    = 1'b0;
        o_iss.rd_eob   = last_rd && (r_second || !r_f2);
        o_rd_addr      = r_idx;
        o_wr_en        = 1'b0;
        o_wr_addr      = r_len[AW-1:0];
        o_wr_data      = r_new;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_differs = differs;
                    n_present = i_item.old_present;
                    n_last    = i_item.last;
                    n_new     = i_item.new_byte;
                    n_f2      = differs && ((len_after >= MAX_L) || i_item.last);
                    n_second  = 1'b0;
                    n_state   = f1 ? S_HDR : S_APP;
                end
            end
            S_HDR: begin
                if (i_credit) begin
                    o_iss.hdr_push = 1'b1;
                    n_idx          = '0;
                    n_state        = S_DATA;
                end
            end
            S_DATA: begin
                if (i_credit) begin
                    o_iss.rd_en = 1'b1;
                    n_idx       = r_idx + 1'b1;
                    if (last_rd) begin
                        n_prior = bdsw_pkg::OFF_W'(i_region_offset + r_run_start
                                                   + bdsw_pkg::OFF_W'(r_len));
                        n_abs   = 1'b0;
                        n_len   = '0;
                        n_tail  = 1'b0;
                        if (r_second) begin
                            finish  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_APP;
                        end
                    end
                end
            end
            S_APP: begin
                if (r_differs) begin
                    if (r_len == '0) begin
                        n_run_start = r_pos;
                        n_tail      = !r_present;
                    end
                    o_wr_en = 1'b1;
                    n_len   = r_len + 1'b1;
                end
                if (r_f2) begin
                    n_second = 1'b1;
                    n_state  = S_HDR;
                end else begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of the item: advance position, region end resets the seek chain
        if (finish) begin
            n_pos = r_pos + 1'b1;
            if (r_last) begin
                n_pos       = '0;
                n_run_start = '0;
                n_prior     = '0;
                n_abs       = 1'b1;
                n_tail      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_run_start <= '0;
            r_pos       <= '0;
            r_prior     <= '0;
            r_abs       <= 1'b1;
            r_tail      <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_run_start <= n_run_start;
            r_pos       <= n_pos;
            r_prior     <= n_prior;
            r_abs       <= n_abs;
            r_tail      <= n_tail;
            r_second    <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_f2      <= n_f2;
        r_differs <= n_differs;
        r_present <= n_present;
        r_last    <= n_last;
        r_new     <= n_new;
    end

`ifndef ASSERT_OFF
    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= MAX_L)
        else $error("run length above limit");

    a_idle_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_len < MAX_L))
        else $error("full run left unflushed");

    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iss.rd_en |-> (LW'(r_idx) < r_len))
        else $error("read beyond held run");

    a_issue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_iss.hdr_push || o_iss.rd_en) |-> i_credit)
        else $error("result issued without queue space");

    a_no_write_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_iss.rd_en |=> !o_wr_en || (r_state == S_APP))
        else $error("store write overlaps run read-out");
`endif

endmodule

@@ rtl/byte_diff_seek_write_encoder_unit.sv @@
// Byte-difference seek-write encoder. Items are old/new byte pairs of one region; differing
// bytes and new-only tail bytes gather into a run of up to RUN_MAX bytes held in a synchronous
// RAM with one write and one read port, and each flushed run comes out as one header result
// (opcode, seek from the previous run's end or absolute for the region's first run, size minus
// one) followed by one result per run byte, end_of_burst on the last result caused by an item.
// An item that causes no flush passes through the idle and append states; each flush adds a
// header step and one read step per run byte, the run bytes leaving at one per cycle through
// the RAM read port into a two-entry output queue; while the output is held off the flush
// waits, and so does the input. Input is taken only between items. Registers (APB, 64-bit
// data): region_offset at 0x0, opcode_base at 0x8; write them while the block is idle. No
// clearing pass after reset.
module byte_diff_seek_write_encoder_unit #(
    parameter int RUN_MAX = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bdsw_in_if.sink                       i_item,
    bdsw_out_if.source                    o_rslt,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdsw_pkg::PADDR_W-1:0]  paddr,
    input  logic [bdsw_pkg::PDATA_W-1:0]  pwdata,
    output logic [bdsw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int LW = $clog2(RUN_MAX + 1);
    localparam int AW = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;

    logic [bdsw_pkg::OFF_W-1:0]  r_region_offset;
    logic [bdsw_pkg::OP_W-1:0]   r_opcode_base;

    bdsw_pkg::t_issue            iss;
    logic                        credit;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [bdsw_pkg::BYTE_W-1:0] wr_data;
    logic [bdsw_pkg::BYTE_W-1:0] rd_data;
    logic                        reg_sel;
    logic                        cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_sel)
            bdsw_pkg::REG_OFFSET: prdata = bdsw_pkg::PDATA_W'(r_region_offset);
            bdsw_pkg::REG_OPBASE: prdata = bdsw_pkg::PDATA_W'(r_opcode_base);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_offset <= '0;
            r_opcode_base   <= '0;
        end else if (cfg_wr) begin
            if (reg_sel == bdsw_pkg::REG_OFFSET) begin
                r_region_offset <= pwdata[bdsw_pkg::OFF_W-1:0];
            end else begin
                r_opcode_base <= pwdata[bdsw_pkg::OP_W-1:0];
            end
        end
    end

    bdsw_ctrl #(
        .RUN_MAX (RUN_MAX),
        .LW      (LW),
        .AW      (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_region_offset (r_region_offset),
        .i_opcode_base   (r_opcode_base),
        .i_credit        (credit),
        .o_iss           (iss),
        .o_rd_addr       (rd_addr),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data)
    );

    bdsw_store #(
        .DEPTH (RUN_MAX),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (iss.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bdsw_oq u_oq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_iss     (iss),
        .i_rd_data (rd_data),
        .o_credit  (credit),
        .o_rslt    (o_rslt)
    );

endmodule
